/* hdl/assert_macros.svh */
// Assertion macros used by the RTL top level to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

/* hdl/jacm_pkg.sv */
// Package with the shared types and constants of the joystick axis map block.
package jacm_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_CALIBRATING = 3'd0;
  localparam logic [2:0] CFG_BTN_LOW     = 3'd1;
  localparam logic [2:0] CFG_BTN_HIGH    = 3'd2;
  localparam logic [2:0] CFG_SAVED_MIN_X = 3'd3;
  localparam logic [2:0] CFG_SAVED_MIN_Y = 3'd4;
  localparam logic [2:0] CFG_SAVED_MAX_X = 3'd5;
  localparam logic [2:0] CFG_SAVED_MAX_Y = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int THRESH_W    = 10;

  localparam logic [THRESH_W-1:0] BTN_LOW_RESET  = 10'd256;
  localparam logic [THRESH_W-1:0] BTN_HIGH_RESET = 10'd768;
  localparam logic [7:0]          SAVED_MIN_RESET = 8'd255;
  localparam logic [7:0]          SAVED_MAX_RESET = 8'd0;

  // Mapping: (v - min) * GAIN / span - OFFSET, saturated to +/- OFFSET
  localparam int QUO_W     = 9;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = 4;
  localparam logic [7:0]       GAIN    = 8'd254;
  localparam logic [QUO_W-1:0] OFFSET  = 9'd127;
  localparam logic [7:0]       POS_MAX = 8'h7f;
  localparam logic [7:0]       POS_MIN = 8'h81;

  // Result packing
  localparam int OUT_FIELDS_W = 49;
  localparam int OUT_DATA_W   = 56;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic setup;
    logic dinit;
    logic step;
    logic finish;
  } dp_cmd_t;

endpackage

/* hdl/jacm_ctrl.sv */
// Controller state machine that sequences one frame through the datapath.
module jacm_ctrl import jacm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Decode state into datapath commands and next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit  = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state and iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Hold the result valid until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/jacm_datapath.sv */
// Datapath: configuration, tracked limits, button trigger and two divider lanes.
module jacm_datapath import jacm_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int IN_W        = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  input  logic [IN_W-1:0]        in_data,
  input  logic                   in_restart,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [OUT_DATA_W-1:0]  out_data
);

  localparam int SB         = SAMPLE_BITS;
  localparam int BYTE_SHIFT = SB - 8;
  localparam int NUM_W      = SB + 8;
  localparam int CMP_W      = (SB > THRESH_W) ? SB : THRESH_W;
  localparam logic [SB-1:0] MID = {1'b1, {(SB-1){1'b0}}};

  logic                calibrating;
  logic [THRESH_W-1:0] btn_low;
  logic [THRESH_W-1:0] btn_high;
  logic [7:0]          saved_min [2];
  logic [7:0]          saved_max [2];

  logic [SB-1:0] smp [2];
  logic [SB-1:0] btn_smp;
  logic          restart;
  logic          btn_state;

  logic [7:0]    pos     [2];
  logic [SB-1:0] trk_min [2];
  logic [SB-1:0] trk_max [2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating  <= 1'b0;
      btn_low      <= BTN_LOW_RESET;
      btn_high     <= BTN_HIGH_RESET;
      saved_min[0] <= SAVED_MIN_RESET;
      saved_min[1] <= SAVED_MIN_RESET;
      saved_max[0] <= SAVED_MAX_RESET;
      saved_max[1] <= SAVED_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CALIBRATING: calibrating  <= cfg_data[0];
        CFG_BTN_LOW:     btn_low      <= cfg_data[THRESH_W-1:0];
        CFG_BTN_HIGH:    btn_high     <= cfg_data[THRESH_W-1:0];
        CFG_SAVED_MIN_X: saved_min[0] <= cfg_data[7:0];
        CFG_SAVED_MIN_Y: saved_min[1] <= cfg_data[7:0];
        CFG_SAVED_MAX_X: saved_max[0] <= cfg_data[7:0];
        CFG_SAVED_MAX_Y: saved_max[1] <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted frame
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp[0]  <= in_data[SB-1:0];
      smp[1]  <= in_data[2*SB-1:SB];
      btn_smp <= in_data[3*SB-1:2*SB];
      restart <= in_restart;
    end
  end

  // Schmitt trigger on the button line
  always_ff @(posedge clk) begin
    if (rst) begin
      btn_state <= 1'b0;
    end else if (cmd.prep) begin
      if (btn_state && (CMP_W'(btn_smp) < CMP_W'(btn_low))) begin
        btn_state <= 1'b0;
      end else if (!btn_state && (CMP_W'(btn_smp) > CMP_W'(btn_high))) begin
        btn_state <= 1'b1;
      end
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic [SB-1:0]    min_r, max_r;
    logic [SB-1:0]    base_min, base_max, new_min, new_max;
    logic [SB-1:0]    lo_r, hi_r;
    logic [SB:0]      diff, span;
    logic [SB-1:0]    adiff, aspan;
    logic [NUM_W-1:0] num_r;
    logic [SB-1:0]    den_r;
    logic             neg_r, zero_r, ovf_r;
    logic [SB-1:0]    rem_r;
    logic [QUO_W-1:0] nlow_r, quo_r;
    logic [SB:0]      rem_sh;
    logic             ge;
    logic [7:0]       pos_c;

    // Restart and widen the tracked limits
    always_comb begin
      base_min = restart ? MID : min_r;
      base_max = restart ? MID : max_r;
      new_min  = (smp[i] < base_min) ? smp[i] : base_min;
      new_max  = (smp[i] > base_max) ? smp[i] : base_max;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        min_r <= MID;
        max_r <= MID;
      end else if (cmd.prep) begin
        min_r <= calibrating ? new_min : base_min;
        max_r <= calibrating ? new_max : base_max;
      end
    end

    // Select the limits that the map uses
    always_ff @(posedge clk) begin
      if (cmd.prep) begin
        lo_r <= calibrating ? new_min : (SB'(saved_min[i]) << BYTE_SHIFT);
        hi_r <= calibrating ? new_max : (SB'(saved_max[i]) << BYTE_SHIFT);
      end
    end

    // Form magnitudes of numerator and divisor
    always_comb begin
      diff  = {1'b0, smp[i]} - {1'b0, lo_r};
      span  = {1'b0, hi_r} - {1'b0, lo_r};
      adiff = diff[SB] ? SB'(-diff) : diff[SB-1:0];
      aspan = span[SB] ? SB'(-span) : span[SB-1:0];
    end

    always_ff @(posedge clk) begin
      if (cmd.setup) begin
        num_r  <= NUM_W'(adiff) * NUM_W'(GAIN);
        den_r  <= aspan;
        neg_r  <= diff[SB] ^ span[SB];
        zero_r <= (span == '0);
      end
    end

    // Restoring divide, one quotient bit per step
    always_comb begin
      rem_sh = {rem_r, nlow_r[QUO_W-1]};
      ge     = (rem_sh >= {1'b0, den_r});
    end

    always_ff @(posedge clk) begin
      if (cmd.dinit) begin
        ovf_r  <= ((num_r >> QUO_W) >= NUM_W'(den_r));
        rem_r  <= SB'(num_r >> QUO_W);
        nlow_r <= num_r[QUO_W-1:0];
        quo_r  <= '0;
      end else if (cmd.step) begin
        rem_r  <= ge ? SB'(rem_sh - {1'b0, den_r}) : rem_sh[SB-1:0];
        nlow_r <= {nlow_r[QUO_W-2:0], 1'b0};
        quo_r  <= {quo_r[QUO_W-2:0], ge};
      end
    end

    // Offset and saturate the quotient
    always_comb begin
      if (zero_r) begin
        pos_c = '0;
      end else if (neg_r) begin
        pos_c = POS_MIN;
      end else if (ovf_r || (quo_r > QUO_W'(GAIN))) begin
        pos_c = POS_MAX;
      end else begin
        pos_c = 8'(quo_r - OFFSET);
      end
    end

    assign pos[i]     = pos_c;
    assign trk_min[i] = min_r;
    assign trk_max[i] = max_r;
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {{OUT_PAD_W{1'b0}},
                   8'(trk_max[1] >> BYTE_SHIFT), 8'(trk_max[0] >> BYTE_SHIFT),
                   8'(trk_min[1] >> BYTE_SHIFT), 8'(trk_min[0] >> BYTE_SHIFT),
                   btn_state, pos[1], pos[0]};
    end
  end

endmodule

/* hdl/joystick_axis_calibrate_map.sv */
// Joystick axis calibration and linear range map, top level.
// Input stream: one frame per transaction, three raw samples in s_axis_tdata
// and the restart-calibration flag in s_axis_tuser. Output stream: one result
// per frame with both mapped positions, the button state and the four
// tracked limits as bytes. Configuration: cfg_index selects a register,
// cfg_data carries its value; cfg_ready is always high, unknown indexes are
// ignored. Write configuration only while no frame is in flight.
// A frame passes through the limit, setup and divider-load steps, the
// nine-step restoring divider that both axes run in parallel (one quotient
// bit per cycle) and the result step; a new frame is taken only after the
// last one has reached the result register.
// s_axis_tready is high only while the block waits for a frame.
// If the receiver stalls, one finished result is held in the output register
// while the next frame is taken and worked; that frame then waits at its last
// step until the output register is free.
// Reset: synchronous on rst; registers return to their defaults, tracked
// limits go to mid scale and the button reads released.
`include "assert_macros.svh"
module joystick_axis_calibrate_map import jacm_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // x_sample, y_sample, button_sample, zero pad
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // restart_calibration
  input  logic [0:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // x_position, y_position, button_pressed, tracked_min_x_byte,
  // tracked_min_y_byte, tracked_max_x_byte, tracked_max_y_byte, zero pad
  output logic [OUT_DATA_W-1:0]                  m_axis_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_data
);

  localparam int IN_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  jacm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  jacm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_W        (IN_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_data    (s_axis_tdata),
    .in_restart (s_axis_tuser[0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_data   (m_axis_tdata)
  );

  // A taken frame keeps the input closed while it is worked
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Never overwrite a result that the receiver has not taken
  `ASSERT_SAME(a_finish_slot_free, clk, rst, cmd.finish, !m_axis_tvalid || m_axis_tready)
  // A new result appears only right after the finish command
  `ASSERT_SAME(a_valid_from_finish, clk, rst, $rose(m_axis_tvalid), $past(cmd.finish))

endmodule

/* sim/jacm_result_checker.sv */
// Result checker for the joystick axis map: tracks the block, predicts each frame and compares.
module jacm_result_checker import jacm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // x_sample, y_sample, button_sample, zero pad
  input  logic [31:0]            s_axis_tdata,
  // restart_calibration
  input  logic [0:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // x_position, y_position, button_pressed, tracked_min_x_byte,
  // tracked_min_y_byte, tracked_max_x_byte, tracked_max_y_byte, zero pad
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     outstanding
);

  localparam logic [9:0] MID_SCALE = 10'd512;

  typedef struct {
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
    logic              pressed;
    logic [7:0]        min_x;
    logic [7:0]        min_y;
    logic [7:0]        max_x;
    logic [7:0]        max_y;
  } axis_result_t;

  // Shadow copy of the registers and the tracking state
  logic       cal_mode;
  logic [9:0] release_level;
  logic [9:0] press_level;
  logic [7:0] saved_min_x, saved_min_y, saved_max_x, saved_max_y;
  logic [9:0] trk_min_x, trk_max_x, trk_min_y, trk_max_y;
  logic       btn_down;

  axis_result_t pending_results[$];

  // Linear map of one sample onto -127..127, truncating toward zero
  function automatic logic signed [7:0] axis_position(logic [9:0] v, logic [9:0] lo,
                                                      logic [9:0] hi);
    int span;
    int pos;
    span = int'(hi) - int'(lo);
    if (span == 0) return 8'sd0;
    pos = (int'(v) - int'(lo)) * 254 / span - 127;
    if (pos > 127) pos = 127;
    if (pos < -127) pos = -127;
    return pos[7:0];
  endfunction

  // Advance the tracking state by one frame and return its result
  function automatic axis_result_t map_frame(logic [9:0] x, logic [9:0] y, logic [9:0] b,
                                             logic restart);
    axis_result_t r;
    if (restart) begin
      trk_min_x = MID_SCALE;
      trk_max_x = MID_SCALE;
      trk_min_y = MID_SCALE;
      trk_max_y = MID_SCALE;
    end
    if (cal_mode) begin
      if (x < trk_min_x) trk_min_x = x;
      if (x > trk_max_x) trk_max_x = x;
      if (y < trk_min_y) trk_min_y = y;
      if (y > trk_max_y) trk_max_y = y;
      r.x_pos = axis_position(x, trk_min_x, trk_max_x);
      r.y_pos = axis_position(y, trk_min_y, trk_max_y);
    end else begin
      r.x_pos = axis_position(x, {saved_min_x, 2'b00}, {saved_max_x, 2'b00});
      r.y_pos = axis_position(y, {saved_min_y, 2'b00}, {saved_max_y, 2'b00});
    end
    // Schmitt trigger: a sample equal to a threshold holds the state
    if (btn_down && b < release_level) btn_down = 1'b0;
    else if (!btn_down && b > press_level) btn_down = 1'b1;
    r.pressed = btn_down;
    r.min_x = trk_min_x[9:2];
    r.min_y = trk_min_y[9:2];
    r.max_x = trk_max_x[9:2];
    r.max_y = trk_max_y[9:2];
    return r;
  endfunction

  function automatic void check_field(string label, int want, int got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    axis_result_t want;
    if (rst) begin
      cal_mode = 1'b0;
      release_level = BTN_LOW_RESET;
      press_level = BTN_HIGH_RESET;
      saved_min_x = SAVED_MIN_RESET;
      saved_min_y = SAVED_MIN_RESET;
      saved_max_x = SAVED_MAX_RESET;
      saved_max_y = SAVED_MAX_RESET;
      trk_min_x = MID_SCALE;
      trk_max_x = MID_SCALE;
      trk_min_y = MID_SCALE;
      trk_max_y = MID_SCALE;
      btn_down = 1'b0;
      pending_results.delete();
    end else begin
      // Register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CALIBRATING: cal_mode = cfg_data[0];
          CFG_BTN_LOW:     release_level = cfg_data[9:0];
          CFG_BTN_HIGH:    press_level = cfg_data[9:0];
          CFG_SAVED_MIN_X: saved_min_x = cfg_data[7:0];
          CFG_SAVED_MIN_Y: saved_min_y = cfg_data[7:0];
          CFG_SAVED_MAX_X: saved_max_x = cfg_data[7:0];
          CFG_SAVED_MAX_Y: saved_max_y = cfg_data[7:0];
          default: ;
        endcase
      end
      // Compare a result transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          failures++;
          $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("x_position", want.x_pos, $signed(m_axis_tdata[7:0]));
          check_field("y_position", want.y_pos, $signed(m_axis_tdata[15:8]));
          check_field("button_pressed", want.pressed, m_axis_tdata[16]);
          check_field("tracked_min_x_byte", want.min_x, m_axis_tdata[24:17]);
          check_field("tracked_min_y_byte", want.min_y, m_axis_tdata[32:25]);
          check_field("tracked_max_x_byte", want.max_x, m_axis_tdata[40:33]);
          check_field("tracked_max_y_byte", want.max_y, m_axis_tdata[48:41]);
          check_field("pad", 0, m_axis_tdata[OUT_DATA_W-1:49]);
        end
      end
      // Predict each accepted frame transaction
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(map_frame(s_axis_tdata[9:0], s_axis_tdata[19:10],
                                            s_axis_tdata[29:20], s_axis_tuser[0]));
    end
    outstanding = pending_results.size();
  end

endmodule

/* sim/tb_joystick_axis_calibrate_map.sv */
// Testbench top for the joystick axis map: drives frames, registers and stalls, gives the verdict.
module tb_joystick_axis_calibrate_map import jacm_pkg::*;;

  localparam int IN_DATA_W   = 32;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 20;
  localparam int SEG_ITEMS   = 175;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int         failures;
  int         outstanding;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic [9:0] cur_low = BTN_LOW_RESET;
  logic [9:0] cur_high = BTN_HIGH_RESET;

  joystick_axis_calibrate_map u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  jacm_result_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Count cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one frame after a random idle gap and hold it until taken
  task automatic send_frame(logic [9:0] x, logic [9:0] y, logic [9:0] b, logic restart);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b, y, x};
    s_axis_tuser  <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop the frame channel and wait until every result is back
  task automatic drain_frames();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write every register once, with the block idle
  task automatic apply_config(logic cal, logic [9:0] lo, logic [9:0] hi, logic [7:0] mnx,
                              logic [7:0] mny, logic [7:0] mxx, logic [7:0] mxy);
    logic [CFG_INDEX_W-1:0] idx[7];
    logic [CFG_DATA_W-1:0]  val[7];
    drain_frames();
    idx = '{CFG_CALIBRATING, CFG_BTN_LOW, CFG_BTN_HIGH, CFG_SAVED_MIN_X, CFG_SAVED_MIN_Y,
            CFG_SAVED_MAX_X, CFG_SAVED_MAX_Y};
    val = '{{9'd0, cal}, lo, hi, {2'b00, mnx}, {2'b00, mny}, {2'b00, mxx}, {2'b00, mxy}};
    for (int i = 0; i < 7; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_low  = lo;
    cur_high = hi;
  endtask

  function automatic logic [9:0] rand_sample();
    case ($urandom_range(7))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'($urandom_range(544, 480));
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // Favor the thresholds themselves and the rails
  function automatic logic [9:0] rand_button();
    case ($urandom_range(7))
      0: return cur_low;
      1: return cur_high;
      2: return 10'd0;
      3: return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [9:0] rand_level();
    case ($urandom_range(5))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int         idle_tab[4];
    int         stall_tab[4];
    logic [9:0] lo, hi, tmp10;
    logic [7:0] mnx, mny, mxx, mxy, tmp8;
    logic       cal;
    idle_tab  = '{0, 83, 0, 15};
    stall_tab = '{0, 0, 83, 15};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limits: inverted saved span, button edges at and past thresholds
    send_frame(10'd0, 10'd1023, 10'd768, 1'b0);
    send_frame(10'd1023, 10'd0, 10'd769, 1'b0);
    send_frame(10'd512, 10'd512, 10'd256, 1'b0);
    send_frame(10'd1023, 10'd1023, 10'd255, 1'b0);
    send_frame(10'd0, 10'd0, 10'd1023, 1'b1);
    send_frame(10'd1, 10'd2, 10'd0, 1'b0);

    // Calibration: zero span after restart, then widening to the rails
    apply_config(1'b1, 10'd0, 10'd1023, 8'd100, 8'd50, 8'd150, 8'd200);
    send_frame(10'd512, 10'd512, 10'd0, 1'b1);
    send_frame(10'd0, 10'd1023, 10'd1023, 1'b0);
    send_frame(10'd1023, 10'd0, 10'd512, 1'b0);
    send_frame(10'd300, 10'd700, 10'd1, 1'b0);
    send_frame(10'd600, 10'd600, 10'd1022, 1'b1);

    // Saved limits with saturation and crossed thresholds
    apply_config(1'b0, 10'd1023, 10'd0, 8'd100, 8'd0, 8'd150, 8'd255);
    send_frame(10'd0, 10'd1023, 10'd0, 1'b0);
    send_frame(10'd1023, 10'd0, 10'd1023, 1'b0);
    send_frame(10'd500, 10'd500, 10'd1, 1'b0);
    send_frame(10'd400, 10'd1020, 10'd0, 1'b0);

    // Saved zero span
    apply_config(1'b0, 10'd256, 10'd768, 8'd128, 8'd128, 8'd128, 8'd128);
    send_frame(10'd512, 10'd512, 10'd800, 1'b0);
    send_frame(10'd0, 10'd1023, 10'd100, 1'b0);

    // Random segments across idling phases and settings
    for (int seg = 0; seg < 8; seg++) begin
      lo  = rand_level();
      hi  = rand_level();
      mnx = rand_byte();
      mny = rand_byte();
      mxx = rand_byte();
      mxy = rand_byte();
      cal = seg[0];
      // Keep most settings ordered so the map stays in range
      if (lo > hi && $urandom_range(3) != 0) begin
        tmp10 = lo; lo = hi; hi = tmp10;
      end
      if (mnx > mxx && $urandom_range(3) != 0) begin
        tmp8 = mnx; mnx = mxx; mxx = tmp8;
      end
      if (mny > mxy && $urandom_range(3) != 0) begin
        tmp8 = mny; mny = mxy; mxy = tmp8;
      end
      apply_config(cal, lo, hi, mnx, mny, mxx, mxy);
      send_idle_pct = idle_tab[seg / 2];
      stall_pct     = stall_tab[seg / 2];
      for (int n = 0; n < SEG_ITEMS; n++)
        send_frame(rand_sample(), rand_sample(), rand_button(),
                   $urandom_range(cal ? 39 : 19) == 0);
    end

    drain_frames();
    repeat (30) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
